// File: sv/q8mh_pkg.sv
`default_nettype none

package q8mh_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_TENSOR = 2'd3;

    // Block layout of the quantized weight stream.
    localparam int BLOCK_BYTES       = 34;
    localparam int SCALE_BYTES       = 2;
    localparam int WEIGHTS_PER_BLOCK = 32;

    // Field widths and limits.
    localparam int POS_W    = 6;
    localparam int OUT_W    = 48;
    localparam int TENSOR_W = 16;
    localparam int MAG_CAP  = 127;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [6:0] bin_index;
    } in_word_t;

    typedef struct packed {
        logic [OUT_W-1:0]    bin_count;
        logic [OUT_W-1:0]    cumulative_count;
        logic [OUT_W-1:0]    above_count;
        logic [OUT_W-1:0]    value_total;
        logic [OUT_W-1:0]    block_total;
        logic [TENSOR_W-1:0] tensor_total;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;
        logic walk_start;
        logic walk_rd;
        logic upd_wr;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_weight;
        logic walk_last;
        logic out_block;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/q8mh_ram.sv
`default_nettype none

module q8mh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/q8mh_ctrl.sv
`default_nettype none

module q8mh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        opcode,
    output q8mh_pkg::dp_cmd_t      cmd,
    input  wire q8mh_pkg::dp_sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (opcode == q8mh_pkg::OP_DATA && sts.in_weight)
                    begin
                        state_next = ST_UPD;
                    end
                    else if (opcode == q8mh_pkg::OP_QUERY)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_UPD:
            begin
                cmd.upd_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!sts.out_block)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/q8mh_dp.sv
`default_nettype none

module q8mh_dp #(
    parameter int BIN_COUNT    = 128,
    parameter int COUNTER_BITS = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire q8mh_pkg::in_word_t   in_data,
    input  wire q8mh_pkg::dp_cmd_t    cmd,
    output q8mh_pkg::dp_sts_t         sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output q8mh_pkg::out_word_t       out_data
);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int CW    = COUNTER_BITS;
    localparam int PW    = q8mh_pkg::POS_W;
    localparam int TW    = q8mh_pkg::TENSOR_W;
    localparam int OW    = q8mh_pkg::OUT_W;
    localparam int WIN_LO = q8mh_pkg::SCALE_BYTES;
    localparam int WIN_HI = q8mh_pkg::SCALE_BYTES + q8mh_pkg::WEIGHTS_PER_BLOCK;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic logic [OW-1:0] cap_out(input logic [CW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (|w[63:OW]) ? {OW{1'b1}} : w[OW-1:0];
    endfunction

    logic            is_data;
    logic            is_clear;
    logic            is_tensor;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   pos_next;
    logic [CW-1:0]   weights_reg;
    logic [CW-1:0]   weights_next;
    logic [CW-1:0]   blocks_reg;
    logic [CW-1:0]   blocks_next;
    logic [TW-1:0]   tensors_reg;
    logic [TW-1:0]   tensors_next;
    logic            block_end;
    logic [7:0]      mag_abs;
    logic [7:0]      mag_cap;
    logic [BIN_W-1:0] mag_addr;
    logic [BIN_W-1:0] mag_reg;
    logic [BIN_COUNT-1:0] bin_vld_reg;
    logic            ram_rd_en;
    logic [BIN_W-1:0] ram_rd_addr;
    logic [CW-1:0]   ram_rd_data;
    logic [CW-1:0]   upd_old;
    logic [CW-1:0]   upd_new;
    logic [BIN_W-1:0] rd_idx_reg;
    logic            pend_reg;
    logic [BIN_W-1:0] acc_idx_reg;
    logic [6:0]      qidx_reg;
    logic [CW-1:0]   acc_val;
    logic [CW-1:0]   here_reg;
    logic [CW-1:0]   through_reg;
    logic [CW-1:0]   above_reg;
    logic            out_vld_reg;
    q8mh_pkg::out_word_t out_reg;

    assign is_data   = cmd.take_in && in_data.opcode == q8mh_pkg::OP_DATA;
    assign is_clear  = cmd.take_in && in_data.opcode == q8mh_pkg::OP_CLEAR;
    assign is_tensor = cmd.take_in && in_data.opcode == q8mh_pkg::OP_TENSOR;

    // Weight window within the current block.
    assign sts.in_weight = (7'(pos_reg) >= 7'(WIN_LO)) && (7'(pos_reg) < 7'(WIN_HI));
    assign block_end     = (7'(pos_reg) + 7'd1) >= 7'(q8mh_pkg::BLOCK_BYTES);

    // Magnitude of the incoming weight, capped at the top bin.
    always_comb
    begin
        mag_abs = in_data.data_byte[7] ? (~in_data.data_byte + 8'd1) : in_data.data_byte;
        mag_cap = (mag_abs > 8'(q8mh_pkg::MAG_CAP)) ? 8'(q8mh_pkg::MAG_CAP) : mag_abs;
        if (9'(mag_cap) > 9'(BIN_COUNT - 1))
        begin
            mag_cap = 8'(BIN_COUNT - 1);
        end
        mag_addr = mag_cap[BIN_W-1:0];
    end

    // Counter updates for data, clear and tensor-start words.
    always_comb
    begin
        pos_next     = pos_reg;
        weights_next = weights_reg;
        blocks_next  = blocks_reg;
        tensors_next = tensors_reg;
        if (is_data)
        begin
            if (sts.in_weight)
            begin
                weights_next = sat_add(weights_reg, CW'(1));
            end
            if (block_end)
            begin
                pos_next    = '0;
                blocks_next = sat_add(blocks_reg, CW'(1));
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
        else if (is_clear)
        begin
            pos_next     = '0;
            weights_next = '0;
            blocks_next  = '0;
            tensors_next = '0;
        end
        else if (is_tensor)
        begin
            pos_next = '0;
            if (tensors_reg != {TW{1'b1}})
            begin
                tensors_next = tensors_reg + TW'(1);
            end
        end
    end

    // Bin memory: read for an update or for the query walk.
    assign ram_rd_en   = cmd.walk_rd || (is_data && sts.in_weight);
    assign ram_rd_addr = cmd.walk_rd ? rd_idx_reg : mag_addr;
    assign upd_old     = bin_vld_reg[mag_reg] ? ram_rd_data : '0;
    assign upd_new     = sat_add(upd_old, CW'(1));

    q8mh_ram #(
        .WIDTH (CW),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk     (clk),
        .wr_en   (cmd.upd_wr),
        .wr_addr (mag_reg),
        .wr_data (upd_new),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Walk over the bins, one entry per cycle.
    assign sts.walk_last = rd_idx_reg == BIN_W'(BIN_COUNT - 1);
    assign acc_val       = bin_vld_reg[acc_idx_reg] ? ram_rd_data : '0;
    assign sts.out_block = out_vld_reg && !out_ready;

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            weights_reg <= '0;
            blocks_reg  <= '0;
            tensors_reg <= '0;
            bin_vld_reg <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            weights_reg <= weights_next;
            blocks_reg  <= blocks_next;
            tensors_reg <= tensors_next;
            pend_reg    <= cmd.walk_rd;
            if (is_clear)
            begin
                bin_vld_reg <= '0;
            end
            else if (cmd.upd_wr)
            begin
                bin_vld_reg[mag_reg] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (is_data)
        begin
            mag_reg <= mag_addr;
        end
        if (cmd.walk_start)
        begin
            qidx_reg    <= in_data.bin_index;
            rd_idx_reg  <= '0;
            here_reg    <= '0;
            through_reg <= '0;
            above_reg   <= '0;
        end
        else
        begin
            if (cmd.walk_rd)
            begin
                rd_idx_reg  <= rd_idx_reg + BIN_W'(1);
                acc_idx_reg <= rd_idx_reg;
            end
            if (pend_reg)
            begin
                if (9'(acc_idx_reg) <= 9'(qidx_reg))
                begin
                    through_reg <= sat_add(through_reg, acc_val);
                end
                else
                begin
                    above_reg <= sat_add(above_reg, acc_val);
                end
                if (9'(acc_idx_reg) == 9'(qidx_reg))
                begin
                    here_reg <= acc_val;
                end
            end
        end
        if (cmd.load_out)
        begin
            out_reg.bin_count        <= cap_out(here_reg);
            out_reg.cumulative_count <= cap_out(through_reg);
            out_reg.above_count      <= cap_out(above_reg);
            out_reg.value_total      <= cap_out(weights_reg);
            out_reg.block_total      <= cap_out(blocks_reg);
            out_reg.tensor_total     <= tensors_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: sv/q8_block_magnitude_histogram.sv
// Magnitude histogram of 8-bit quantized weight blocks. Each input word is a data byte, a
// bin query, a clear or a tensor start; only a query returns a result word. A weight byte
// does a read-modify-write of its bin through the registered read port of the bin RAM;
// data bytes in the scale positions of a block, clears and tensor starts do not. A query
// walks the bins one RAM entry per cycle to form the cumulative and above sums. The
// result sits in an output register, so the next word is taken while it waits. Each bin
// has a valid bit in flip-flops, so reset and clear take effect at once with no sweep.
// The bin, weight and block counters saturate at 2^COUNTER_BITS - 1, the tensor counter
// at 2^16 - 1, and the 48-bit result fields saturate too.
`default_nettype none

module q8_block_magnitude_histogram #(
    parameter int BIN_COUNT    = 128,
    parameter int COUNTER_BITS = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire q8mh_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output q8mh_pkg::out_word_t      out_data
);

    q8mh_pkg::dp_cmd_t cmd;
    q8mh_pkg::dp_sts_t sts;

    q8mh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (in_data.opcode),
        .cmd      (cmd),
        .sts      (sts)
    );

    q8mh_dp #(
        .BIN_COUNT    (BIN_COUNT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: sv/q8mh_checker.sv
`default_nettype none

module q8mh_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire q8mh_pkg::in_word_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire q8mh_pkg::out_word_t out_data
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // An accepted query starts the bin walk, which blocks input.
    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode == q8mh_pkg::OP_QUERY |=> !in_ready)
        else $error("input taken during bin walk");

    // Clear and tensor start leave the input ready in the cycle after they are taken.
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.opcode == q8mh_pkg::OP_CLEAR ||
        in_data.opcode == q8mh_pkg::OP_TENSOR) |=> in_ready)
        else $error("clear or tensor start stalled input");

    // The queried bin is part of the cumulative sum.
    a_bin_le_cum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bin_count <= out_data.cumulative_count)
        else $error("bin count exceeds cumulative count");

endmodule

bind q8_block_magnitude_histogram q8mh_checker u_q8mh_checker (.*);

`default_nettype wire

// File: verif/q8_block_magnitude_histogram_test.sv
`default_nettype none

module q8_block_magnitude_histogram_test;

    localparam int NUM_BINS    = 128;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 140;
    localparam int RANDOM_WORDS = 1850;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    q8mh_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    q8mh_pkg::out_word_t out_data;

    q8_block_magnitude_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the histogram state.
    logic [q8mh_pkg::OUT_W-1:0]    model_bins [NUM_BINS];
    int                            model_pos;
    logic [q8mh_pkg::OUT_W-1:0]    model_weights;
    logic [q8mh_pkg::OUT_W-1:0]    model_blocks;
    logic [q8mh_pkg::TENSOR_W-1:0] model_tensors;

    // Query answers still owed by the block, oldest first.
    q8mh_pkg::out_word_t pending_reports [$];

    int errors;
    int words_sent;
    int reports_checked;
    int burst_left;
    bit steady;
    int hold_requests;
    int hold_served;
    int hold_left;
    int rx_cycle;

    typedef struct {
        q8mh_pkg::in_word_t  word;
        bit                  fixed_on;
        q8mh_pkg::out_word_t fixed_val;
    } dir_row_t;

    dir_row_t directed_rows [$];

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [q8mh_pkg::OUT_W-1:0] sat_inc(
        input logic [q8mh_pkg::OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [q8mh_pkg::OUT_W-1:0] sat_sum(
        input logic [q8mh_pkg::OUT_W-1:0] a,
        input logic [q8mh_pkg::OUT_W-1:0] b);
        logic [q8mh_pkg::OUT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[q8mh_pkg::OUT_W] ? '1 : s[q8mh_pkg::OUT_W-1:0];
    endfunction

    function automatic q8mh_pkg::in_word_t mk_word(input logic [1:0] op, input logic [7:0] b,
                                                   input logic [6:0] idx);
        q8mh_pkg::in_word_t w;
        w.opcode    = op;
        w.data_byte = b;
        w.bin_index = idx;
        return w;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] b,
                                        input logic [6:0] idx, input bit fixed_on,
                                        input q8mh_pkg::out_word_t fixed_val);
        dir_row_t r;
        r.word      = mk_word(op, b, idx);
        r.fixed_on  = fixed_on;
        r.fixed_val = fixed_val;
        return r;
    endfunction

    // Weight bytes biased toward the interesting magnitudes.
    function automatic logic [7:0] pick_weight();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b = 8'($urandom_range(0, 255));
            4, 5, 6:    b = 8'($urandom_range(0, 8) - 4);
            7:          b = 8'h80;
            8:          b = $urandom_range(0, 1) ? 8'h7F : 8'h81;
            default:    b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] pick_bin();
        logic [6:0] idx;
        case ($urandom_range(0, 3))
            0:       idx = 7'($urandom_range(0, 5));
            1:       idx = 7'd127;
            default: idx = 7'($urandom_range(0, 127));
        endcase
        return idx;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < NUM_BINS; i++)
            model_bins[i] = '0;
        model_pos     = 0;
        model_weights = '0;
        model_blocks  = '0;
        model_tensors = '0;
    endtask

    // Advance the shadow histogram by one accepted word.
    task automatic histo_apply(input q8mh_pkg::in_word_t w, input bit fixed_on,
                               input q8mh_pkg::out_word_t fixed_val);
        q8mh_pkg::out_word_t        rep;
        logic [q8mh_pkg::OUT_W-1:0] through;
        logic [q8mh_pkg::OUT_W-1:0] above;
        int                         mag;
        case (w.opcode)
            q8mh_pkg::OP_DATA:
            begin
                if (model_pos >= q8mh_pkg::SCALE_BYTES &&
                    model_pos < q8mh_pkg::SCALE_BYTES + q8mh_pkg::WEIGHTS_PER_BLOCK)
                begin
                    mag = w.data_byte[7] ? 256 - int'(w.data_byte) : int'(w.data_byte);
                    if (mag > q8mh_pkg::MAG_CAP)
                        mag = q8mh_pkg::MAG_CAP;
                    model_bins[mag] = sat_inc(model_bins[mag]);
                    model_weights   = sat_inc(model_weights);
                end
                if (model_pos + 1 >= q8mh_pkg::BLOCK_BYTES)
                begin
                    model_pos    = 0;
                    model_blocks = sat_inc(model_blocks);
                end
                else
                begin
                    model_pos = model_pos + 1;
                end
            end
            q8mh_pkg::OP_QUERY:
            begin
                through = '0;
                above   = '0;
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    if (i <= int'(w.bin_index))
                        through = sat_sum(through, model_bins[i]);
                    else
                        above = sat_sum(above, model_bins[i]);
                end
                rep.bin_count        = model_bins[w.bin_index];
                rep.cumulative_count = through;
                rep.above_count      = above;
                rep.value_total      = model_weights;
                rep.block_total      = model_blocks;
                rep.tensor_total     = model_tensors;
                pending_reports.push_back(fixed_on ? fixed_val : rep);
            end
            q8mh_pkg::OP_CLEAR:
            begin
                clear_model();
            end
            default:
            begin
                model_pos = 0;
                if (model_tensors != '1)
                    model_tensors = model_tensors + 1'b1;
            end
        endcase
    endtask

    // Offer one word, wait for the handshake, then maybe take a gap.
    task automatic send_word(input q8mh_pkg::in_word_t w, input bit fixed_on,
                             input q8mh_pkg::out_word_t fixed_val);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        histo_apply(w, fixed_on, fixed_val);
        words_sent++;
        if (!steady)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 4);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(0, 12);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send(input q8mh_pkg::in_word_t w);
        send_word(w, 1'b0, '0);
    endtask

    // Stop offering, then wait for every owed answer and let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [q8mh_pkg::OUT_W-1:0] want,
                                 input logic [q8mh_pkg::OUT_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none outstanding, expected nothing, got %h",
                         $time, out_data);
            end
            else
            begin
                compare_field("bin_count", pending_reports[0].bin_count, out_data.bin_count);
                compare_field("cumulative_count", pending_reports[0].cumulative_count,
                              out_data.cumulative_count);
                compare_field("above_count", pending_reports[0].above_count,
                              out_data.above_count);
                compare_field("value_total", pending_reports[0].value_total,
                              out_data.value_total);
                compare_field("block_total", pending_reports[0].block_total,
                              out_data.block_total);
                compare_field("tensor_total",
                              q8mh_pkg::OUT_W'(pending_reports[0].tensor_total),
                              q8mh_pkg::OUT_W'(out_data.tensor_total));
                void'(pending_reports.pop_front());
                reports_checked++;
            end
        end
    end

    // Receiver: rotates through stall patterns and serves long hold requests.
    initial
    begin
        out_ready   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        rx_cycle    = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 300) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((rx_cycle % 5) < 2);
                endcase
            end
        end
    end

    // Main sequence.
    initial
    begin
        q8mh_pkg::out_word_t zero_rep;
        int                  start_count;
        int                  nblocks;
        int                  nbytes;
        int                  nnoise;
        bit                  paused;
        logic [1:0]          op;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        errors        = 0;
        words_sent    = 0;
        reports_checked = 0;
        burst_left    = 0;
        steady        = 1'b0;
        hold_requests = 0;
        paused        = 1'b0;
        clear_model();

        zero_rep = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: empty histogram, a partial block with every magnitude extreme,
        // a tensor start that drops it, and a clear.
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd0,   1'b1, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'hFF, 7'd127, 1'b1, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_TENSOR, 8'h00, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h12, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h80, 7'd127, 1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h00, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h7F, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h80, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h81, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'hFF, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h01, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd127, 1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'hFF, 7'd1,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_TENSOR, 8'hFF, 7'd127, 1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'hAA, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'h55, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_DATA,   8'hC0, 7'd0,   1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd64,  1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_CLEAR,  8'hFF, 7'd127, 1'b0, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd127, 1'b1, zero_rep));
        directed_rows.push_back(mk_row(q8mh_pkg::OP_QUERY,  8'h00, 7'd0,   1'b1, zero_rep));

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].fixed_on,
                      directed_rows[i].fixed_val);
        wait_drained();

        // Long receiver stall while queries and data keep coming: the output
        // register fills and the input must back up.
        steady = 1'b1;
        hold_requests++;
        send(mk_word(q8mh_pkg::OP_TENSOR, 8'h00, 7'd0));
        for (int i = 0; i < 12; i++)
        begin
            send(mk_word(q8mh_pkg::OP_QUERY, 8'($urandom()), pick_bin()));
            for (int j = 0; j < 5; j++)
                send(mk_word(q8mh_pkg::OP_DATA, pick_weight(), 7'($urandom())));
        end
        steady = 1'b0;
        wait_drained();

        // Random part: mostly aligned tensors of whole blocks with queries
        // sprinkled in, plus cut-short blocks and noise.
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            if (!paused && words_sent - start_count > RANDOM_WORDS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    send(mk_word(q8mh_pkg::OP_TENSOR, 8'($urandom()), 7'($urandom())));
                    nblocks = $urandom_range(1, 3);
                    for (int b = 0; b < nblocks; b++)
                    begin
                        for (int i = 0; i < q8mh_pkg::BLOCK_BYTES; i++)
                        begin
                            send(mk_word(q8mh_pkg::OP_DATA,
                                         (i < q8mh_pkg::SCALE_BYTES) ? 8'($urandom())
                                                                     : pick_weight(),
                                         7'($urandom())));
                            if ($urandom_range(0, 24) == 0)
                                send(mk_word(q8mh_pkg::OP_QUERY, 8'($urandom()),
                                             pick_bin()));
                        end
                    end
                    if ($urandom_range(0, 1) == 0)
                        send(mk_word(q8mh_pkg::OP_QUERY, 8'($urandom()), pick_bin()));
                end
                7, 8:
                begin
                    nbytes = $urandom_range(1, q8mh_pkg::BLOCK_BYTES - 1);
                    for (int i = 0; i < nbytes; i++)
                        send(mk_word(q8mh_pkg::OP_DATA, pick_weight(), 7'($urandom())));
                    send(mk_word(q8mh_pkg::OP_QUERY, 8'($urandom()), pick_bin()));
                end
                default:
                begin
                    nnoise = $urandom_range(1, 6);
                    for (int i = 0; i < nnoise; i++)
                    begin
                        op = 2'($urandom_range(0, 3));
                        if (op == q8mh_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
                            op = q8mh_pkg::OP_QUERY;
                        send(mk_word(op, 8'($urandom()), 7'($urandom())));
                    end
                end
            endcase
        end

        wait_drained();

        $display("Sent %0d words and checked %0d query answers, %0d mismatches.",
                 words_sent, reports_checked, errors);
        $display("Covered magnitude extremes, a long output stall that backs up the input,");
        $display("dropped partial blocks, clears and random block streams under back-pressure.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/q8mh_pkg.sv
sv/q8mh_ram.sv
sv/q8mh_ctrl.sv
sv/q8mh_dp.sv
sv/q8_block_magnitude_histogram.sv
sv/q8mh_checker.sv
verif/q8_block_magnitude_histogram_test.sv
